>>> rtl/pctd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg
// shared types, character codes and hex helpers for the percent decoder
// ----------------------------------------------------------------------------
package pctd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  localparam int unsigned MAX_RES = 3;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    HELD_NONE    = 2'd0,
    HELD_PERCENT = 2'd1,
    HELD_DIGIT   = 2'd2
  } held_t;

  typedef struct packed {
    logic [7:0] byte_v;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t [2:0] res;
  } res_group_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
    hex_val = t[3:0];
  endfunction

endpackage

>>> rtl/pctd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_decode
// escape decoder: holds the lookahead state and turns one byte into up to
// three result items
// ----------------------------------------------------------------------------
module pctd_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output pctd_pkg::res_group_t grp
);
  import pctd_pkg::*;

  held_t      held_r, held_nxt;
  logic [7:0] digit_r, digit_nxt;

  logic [1:0] pre_n;
  res_t [1:0] pre;
  logic       do_fresh;
  logic       fresh_emit;
  held_t      fresh_held;
  res_t       fresh_res;

  always_comb begin
    fresh_emit      = !(in_byte == CH_PERCENT && !in_last);
    fresh_held      = fresh_emit ? HELD_NONE : HELD_PERCENT;
    fresh_res.byte_v = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    fresh_res.last  = in_last;
  end

  always_comb begin
    held_nxt  = held_r;
    digit_nxt = digit_r;
    pre_n     = 2'd0;
    pre[0]    = '{byte_v: CH_PERCENT, last: 1'b0};
    pre[1]    = '{byte_v: digit_r, last: 1'b0};
    do_fresh  = 1'b0;
    case (held_r)
      HELD_PERCENT: begin
        if (is_hex(in_byte) && !in_last) begin
          held_nxt  = HELD_DIGIT;
          digit_nxt = in_byte;
        end else begin
          pre_n    = 2'd1;
          do_fresh = 1'b1;
        end
      end
      HELD_DIGIT: begin
        if (is_hex(in_byte)) begin
          held_nxt  = HELD_NONE;
          pre_n     = 2'd1;
          pre[0]    = '{byte_v: {hex_val(digit_r), hex_val(in_byte)}, last: in_last};
        end else begin
          pre_n    = 2'd2;
          do_fresh = 1'b1;
        end
      end
      default: do_fresh = 1'b1;
    endcase
    if (do_fresh) held_nxt = fresh_held;
  end

  always_comb begin
    grp.res[0] = pre[0];
    grp.res[1] = pre[1];
    grp.res[2] = fresh_res;
    grp.count  = pre_n;
    if (do_fresh && fresh_emit) begin
      grp.res[pre_n] = fresh_res;
      grp.count      = pre_n + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= HELD_NONE;
      digit_r <= 8'h00;
    end else if (step) begin
      held_r  <= held_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

>>> rtl/pctd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_queue
// result queue: takes a group of up to three items at once and, while
// out_ready is high, hands out one item per cycle
// ----------------------------------------------------------------------------
module pctd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pctd_pkg::res_group_t grp,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pctd_pkg::res_t       out_res
);
  import pctd_pkg::*;

  res_t [Q_DEPTH-1:0] mem_r;
  logic [Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]    count_r, count_nxt;
  logic               pop;
  logic [1:0]         n_push;

  assign room      = (count_r <= Q_CW'(Q_DEPTH - MAX_RES));
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign n_push    = push ? grp.count : 2'd0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_AW'(n_push);
    rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
    count_nxt  = count_r + Q_CW'(n_push) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < n_push) mem_r[wr_ptr_r + Q_AW'(i)] <= grp.res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/percent_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_decoder
// url percent decoder on a byte stream
// ----------------------------------------------------------------------------
// One raw byte per item in, decoded bytes out. "%hh" (either case) becomes
// one byte, '+' becomes a space, a broken escape passes through literally
// and the breaking byte is decoded afresh; held lookahead is flushed at
// tlast. An item is registered on entry and decoded from that register into
// up to three results that go into a four-entry output queue when it has
// room; the queue drains one item per cycle while out_tready is high. Input
// throughput is one item per cycle while each input yields at most one result
// and the output is ready; the queue admits a decode only when it holds at
// most one item, so multi-result bursts stall the input.
// ----------------------------------------------------------------------------
module percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);
  import pctd_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       room;
  logic       s1_fire;
  res_group_t grp;
  res_t       out_res;

  assign s1_fire   = s1_valid_r && room;
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  pctd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_fire),
    .in_byte (s1_byte_r),
    .in_last (s1_last_r),
    .grp     (grp)
  );

  pctd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_fire),
    .grp       (grp),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.byte_v;
  assign out_tlast = out_res.last;

endmodule

>>> tb/sv/tb_percent_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_percent_decoder
// self-checking testbench for the url percent decoder
// ----------------------------------------------------------------------------
// Drives byte strings into the decoder and predicts every decoded byte:
// valid escapes in both cases, '+' to space, broken escapes and lookahead
// that is flushed at the end of a string. Directed strings come first. Then
// come random strings, mostly well-formed escapes with plain text and noise
// mixed in. Both sides idle at random, with one stretch at full rate and a
// pause until the output queue has drained.
// ----------------------------------------------------------------------------
module tb_percent_decoder;
  import pctd_pkg::*;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_byte
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic       out_tlast;

  percent_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state as predicted
  held_t       held     = HELD_NONE;
  logic [7:0]  held_dig = 8'h00;
  res_t        decoded_q[$];

  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned strings     = 0;
  int unsigned bytes_out   = 0;
  int unsigned escapes_out = 0;
  bit          gaps_on     = 1'b1;
  bit          stalls_on   = 1'b1;
  logic [7:0]  text_q[$];

  function automatic bit hex_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
    return v[3:0];
  endfunction

  function automatic void emit(input logic [7:0] b, input logic l);
    res_t r;
    r.byte_v = b;
    r.last   = l;
    decoded_q.push_back(r);
  endfunction

  // byte seen with nothing held
  function automatic void decode_fresh(input logic [7:0] b, input logic l);
    if (b == CH_PERCENT && !l) begin
      held = HELD_PERCENT;
    end else begin
      held = HELD_NONE;
      emit((b == CH_PLUS) ? CH_SPACE : b, l);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic l);
    case (held)
      HELD_PERCENT: begin
        if (hex_char(b) && !l) begin
          held_dig = b;
          held     = HELD_DIGIT;
        end else begin
          emit(CH_PERCENT, 1'b0);
          decode_fresh(b, l);
        end
      end
      HELD_DIGIT: begin
        if (hex_char(b)) begin
          held = HELD_NONE;
          emit({nibble(held_dig), nibble(b)}, l);
          escapes_out++;
        end else begin
          emit(CH_PERCENT, 1'b0);
          emit(held_dig, 1'b0);
          decode_fresh(b, l);
        end
      end
      default: begin
        decode_fresh(b, l);
      end
    endcase
  endfunction

  // accepted input items feed the prediction, accepted results are checked
  always @(posedge clk) begin
    res_t want;
    if (rst_n && in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      bytes_out++;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected item byte %02h last %0b", $time, out_tdata, out_tlast);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata !== want.byte_v) begin
          $display("%0t: out byte expected %02h actual %02h", $time, want.byte_v,
                   out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: out last expected %0b actual %0b", $time, want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // mostly short, a few long
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  int unsigned ready_cnt = 0;
  always @(posedge clk) begin
    if (ready_cnt == 0) begin
      if (!stalls_on || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        ready_cnt = $urandom_range(1, 12);
      end else begin
        out_tready <= 1'b0;
        ready_cnt = pause_len();
      end
    end else begin
      ready_cnt--;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) >= 55) gap = pause_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (l) strings++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_text_q();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    if ($urandom_range(0, 1) == 0) return 8'(8'h41 + v - 10);
    return 8'(8'h61 + v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_char(c));
    return c;
  endfunction

  // a string built from escapes, plain text, plus signs, broken escapes and noise
  task automatic make_random_text();
    int unsigned pieces;
    int unsigned r;
    text_q.delete();
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        text_q.push_back(CH_PERCENT);
        text_q.push_back(rand_hex());
        text_q.push_back(rand_hex());
      end else if (r < 60) begin
        text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (r < 70) begin
        text_q.push_back(CH_PLUS);
      end else if (r < 80) begin
        text_q.push_back(CH_PERCENT);
        if ($urandom_range(0, 1) == 0) text_q.push_back(rand_hex());
        if ($urandom_range(0, 1) == 0) text_q.push_back(rand_non_hex());
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_plain_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("a+ ");
  endtask

  task automatic test_escapes();
    send_text("%4a%F2");
  endtask

  task automatic test_broken_escapes();
    // percent broken by percent, then digit broken by plus
    send_text("%%4+x");
  endtask

  task automatic test_percent_at_end();
    send_text("%");
    send_text("a%");
    send_text("%4");
    send_text("%4g");
    send_text("%5e");
  endtask

  task automatic test_full_rate();
    int unsigned stop_at;
    stop_at = items_sent + 40;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (items_sent < stop_at) begin
      make_random_text();
      send_text_q();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_random_strings();
    int unsigned stop_at;
    int unsigned pause_at;
    bit          paused;
    stop_at  = items_sent + 116;
    pause_at = items_sent + 50;
    paused   = 1'b0;
    while (items_sent < stop_at) begin
      make_random_text();
      send_text_q();
      if (!paused && items_sent >= pause_at) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_bytes();
    test_escapes();
    test_broken_escapes();
    test_percent_at_end();
    test_full_rate();
    test_random_strings();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d input items in %0d strings with random idling on both sides",
             items_sent, strings);
    $display("checked %0d decoded items, %0d of them from escapes", bytes_out, escapes_out);
    if (errors == 0) begin
      $display("tb_percent_decoder OK");
    end else begin
      $display("tb_percent_decoder NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d items still expected", $time, decoded_q.size());
    $display("tb_percent_decoder NOT OK");
    $finish;
  end

endmodule
